@@ rtl/uqap_pkg.sv @@
// ----------------------------------------------------------------------------
// uqap_pkg
// Shared types, result kind codes and helpers for the query string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package uqap_pkg;

    localparam logic [2:0] KIND_KEY_BYTE  = 3'd0;
    localparam logic [2:0] KIND_VAL_BYTE  = 3'd1;
    localparam logic [2:0] KIND_KEY_DONE  = 3'd2;
    localparam logic [2:0] KIND_PAIR_DONE = 3'd3;
    localparam logic [2:0] KIND_KEY_DROP  = 3'd4;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_KEY   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       end_of_query;
    } t_result;

    // One accepted byte's worth of results: res0 always, res1 when two is set.
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/uqap_in_if.sv @@
// ----------------------------------------------------------------------------
// uqap_in_if
// Input channel: one query string character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface uqap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] query_byte;
    logic       final_byte;

    modport source (output valid, output query_byte, output final_byte, input ready);
    modport sink   (input valid, input query_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/uqap_out_if.sv @@
// ----------------------------------------------------------------------------
// uqap_out_if
// Output channel: one decoded byte or marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface uqap_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic       end_of_query;

    modport source (output valid, output kind, output data, output end_of_query, input ready);
    modport sink   (input valid, input kind, input data, input end_of_query, output ready);
endinterface

`default_nettype wire

@@ rtl/url_query_argument_parser.sv @@
// ----------------------------------------------------------------------------
// url_query_argument_parser
// Query string splitter and percent decoder: one char/cycle unless stalled.
//
//   port      dir  transfer               payload
//   i_query   in   one character          query_byte[7:0], final_byte
//   o_result  out  one byte or marker     kind[2:0], data[7:0], end_of_query
//
// One character is taken per cycle while the two-entry queue has room.
// A character's results pass through the queue and then the output register.
// A character with two results (split marker or decoded byte plus end
// marker) uses the output register twice, once for each result.
// Reset is synchronous; it clears parse state, queue and output valid.
// Output stalls fill the queue and then drop i_query.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module url_query_argument_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    uqap_in_if.sink    i_query,
    uqap_out_if.source o_result
);

    logic             push, full, head_valid, pop;
    uqap_pkg::t_entry wr_entry, head;

    uqap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (i_query),
        .i_full  (full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    uqap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .o_rdata (head),
        .i_pop   (pop)
    );

    uqap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

@@ rtl/uqap_front.sv @@
// ----------------------------------------------------------------------------
// uqap_front
// Splits the string into keys and values, percent decodes each token and
// packs the one or two results of a character into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module uqap_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    uqap_in_if.sink         i_query,
    input  wire             i_full,
    output logic            o_push,
    output uqap_pkg::t_entry o_entry
);

    uqap_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_esc, n_esc;
    logic [3:0]       r_hi, n_hi;
    logic             r_trunc, n_trunc;

    logic [7:0] b;
    logic       fin;
    logic       accept;
    logic       split_amp, split_eq, lead_amp;
    logic       new_tok;
    logic       dec_en;
    logic [2:0] dec_kind;
    logic       dec_put;
    logic [7:0] dec_data;
    logic [4:0] hx;
    logic       first_put;
    uqap_pkg::t_result first_res, tail_res;

    assign b      = i_query.query_byte;
    assign fin    = i_query.final_byte;
    assign accept = i_query.valid && i_query.ready;
    assign i_query.ready = !i_full;
    assign hx     = uqap_pkg::hex_value(b);

    assign split_amp = (r_phase == uqap_pkg::PH_VALUE) && (b == uqap_pkg::CH_AMP);
    assign lead_amp  = (r_phase != uqap_pkg::PH_VALUE) && (r_phase != uqap_pkg::PH_KEY)
                       && (b == uqap_pkg::CH_AMP);
    assign split_eq  = (r_phase != uqap_pkg::PH_VALUE) && !lead_amp
                       && (b == uqap_pkg::CH_EQUAL);
    assign new_tok   = split_amp || lead_amp || split_eq;
    assign dec_en    = !new_tok;
    assign dec_kind  = (r_phase == uqap_pkg::PH_VALUE) ? uqap_pkg::KIND_VAL_BYTE
                                                       : uqap_pkg::KIND_KEY_BYTE;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (fin) begin
                n_phase = uqap_pkg::PH_START;
            end else if (split_eq) begin
                n_phase = uqap_pkg::PH_VALUE;
            end else if (r_phase != uqap_pkg::PH_VALUE) begin
                n_phase = uqap_pkg::PH_KEY;
            end else if (split_amp) begin
                n_phase = uqap_pkg::PH_KEY;
            end
        end
    end

    // token decode and results
    always_comb begin
        n_esc    = r_esc;
        n_hi     = r_hi;
        n_trunc  = r_trunc;
        dec_put  = 1'b0;
        dec_data = b;
        if (dec_en && !r_trunc) begin
            unique case (r_esc)
                uqap_pkg::ESC_HIGH: begin
                    if (!hx[4]) begin
                        n_trunc = 1'b1;
                        n_esc   = uqap_pkg::ESC_NONE;
                    end else begin
                        n_hi  = hx[3:0];
                        n_esc = uqap_pkg::ESC_LOW;
                    end
                end
                uqap_pkg::ESC_LOW: begin
                    n_esc    = uqap_pkg::ESC_NONE;
                    dec_data = {r_hi, hx[3:0]};
                    if (!hx[4] || dec_data == 8'd0) begin
                        n_trunc = 1'b1;
                    end else begin
                        dec_put = 1'b1;
                    end
                end
                default: begin
                    if (b == uqap_pkg::CH_PLUS) begin
                        dec_put  = 1'b1;
                        dec_data = uqap_pkg::CH_SPACE;
                    end else if (b == uqap_pkg::CH_PERCENT) begin
                        n_esc = uqap_pkg::ESC_HIGH;
                    end else if (b == 8'd0) begin
                        n_trunc = 1'b1;
                    end else begin
                        dec_put = 1'b1;
                    end
                end
            endcase
        end
        if (new_tok || fin) begin
            n_esc   = uqap_pkg::ESC_NONE;
            n_hi    = 4'd0;
            n_trunc = 1'b0;
        end
        if (!accept) begin
            n_esc   = r_esc;
            n_hi    = r_hi;
            n_trunc = r_trunc;
        end

        first_put              = split_amp || split_eq || dec_put;
        first_res.end_of_query = 1'b0;
        if (split_amp) begin
            first_res.kind = uqap_pkg::KIND_PAIR_DONE;
            first_res.data = 8'd0;
        end else if (split_eq) begin
            first_res.kind = uqap_pkg::KIND_KEY_DONE;
            first_res.data = 8'd0;
        end else begin
            first_res.kind = dec_kind;
            first_res.data = dec_data;
        end

        tail_res.data         = 8'd0;
        tail_res.end_of_query = 1'b1;
        if (split_eq || (r_phase == uqap_pkg::PH_VALUE && !split_amp)) begin
            tail_res.kind = uqap_pkg::KIND_PAIR_DONE;
        end else begin
            tail_res.kind = uqap_pkg::KIND_KEY_DROP;
        end

        o_push        = accept && (first_put || fin);
        o_entry.two   = first_put && fin;
        o_entry.res0  = first_put ? first_res : tail_res;
        o_entry.res1  = tail_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uqap_pkg::PH_START;
            r_esc   <= uqap_pkg::ESC_NONE;
            r_hi    <= 4'd0;
            r_trunc <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_hi    <= n_hi;
            r_trunc <= n_trunc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/uqap_queue.sv @@
// ----------------------------------------------------------------------------
// uqap_queue
// Two-entry queue of result entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module uqap_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  uqap_pkg::t_entry i_wdata,
    output logic             o_full,
    output logic             o_valid,
    output uqap_pkg::t_entry o_rdata,
    input  wire              i_pop
);

    uqap_pkg::t_entry r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/uqap_back.sv @@
// ----------------------------------------------------------------------------
// uqap_back
// Unpacks queue entries into single results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uqap_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_head_valid,
    input  uqap_pkg::t_entry i_head,
    output logic             o_pop,
    uqap_out_if.source       o_result
);

    logic              r_ovalid, n_ovalid;
    logic              r_sel, n_sel;
    uqap_pkg::t_result r_res, n_res;
    logic              load;

    assign load = !r_ovalid || o_result.ready;

    always_comb begin
        n_ovalid = r_ovalid;
        n_sel    = r_sel;
        n_res    = r_res;
        o_pop    = 1'b0;
        if (load) begin
            n_ovalid = i_head_valid;
            if (i_head_valid) begin
                n_res = r_sel ? i_head.res1 : i_head.res0;
                if (r_sel || !i_head.two) begin
                    o_pop = 1'b1;
                    n_sel = 1'b0;
                end else begin
                    n_sel = 1'b1;
                end
            end
        end
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.kind         = r_res.kind;
    assign o_result.data         = r_res.data;
    assign o_result.end_of_query = r_res.end_of_query;

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_sel    <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            r_sel    <= n_sel;
        end
    end

endmodule

`default_nettype wire
